// File: hdl/ktc_pkg.sv
// Shared types, constants and key-compare functions for the keyed texture cache.
package ktc_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int IDLE_W       = 16;
  localparam int IDLE_RESET   = 16 * 5;

  // Entry row layout, identical to the input tdata layout
  localparam int OUTLINE_W    = 384;
  localparam int BLUR_LO      = 384;
  localparam int HANDLE_LO    = 416;
  localparam int FRAME_LO     = 448;
  localparam int ROW_W        = 480;
  localparam int WORD32       = 32;
  localparam int OUT_DATA_W   = 40;
  localparam int OUT_USED_W   = 34;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_SWEEP  = 2'd2,
    OP_NONE   = 2'd3
  } ktc_op_t;

  typedef enum logic [1:0] {
    KIND_LOOKUP  = 2'd0,
    KIND_INSERT  = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_DONE    = 2'd3
  } ktc_kind_t;

  typedef enum logic [1:0] {
    ADDR_IDX,
    ADDR_NEXT,
    ADDR_LAST
  } ktc_addr_t;

  typedef enum logic [1:0] {
    WR_INSERT,
    WR_TOUCH,
    WR_MOVE
  } ktc_wr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_LK_CHK,
    S_LK_HIT,
    S_LK_MISS,
    S_INS,
    S_SW_CHK,
    S_SW_REL,
    S_SW_MV,
    S_SW_DONE
  } ktc_state_t;

  typedef struct packed {
    logic      latch;
    logic      rd_en;
    ktc_addr_t addr_sel;
    logic      idx_inc;
    logic      wr_en;
    ktc_wr_t   wr_sel;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      emit;
    ktc_kind_t kind;
    logic      found;
    logic      full;
    logic      last;
    logic      tex_row;
  } ktc_cmd_t;

  typedef struct packed {
    ktc_op_t op;
    logic    count_zero;
    logic    full;
    logic    hit;
    logic    expired;
    logic    idx_last;
    logic    slot_free;
  } ktc_status_t;

  function automatic logic is_nan32(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  // Float equality on bit patterns: signed zeros match, NaN never does
  function automatic logic blur_equal(input logic [31:0] a, input logic [31:0] b);
    logic res;
    if (is_nan32(a) || is_nan32(b)) begin
      res = 1'b0;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      res = 1'b1;
    end else begin
      res = (a == b);
    end
    return res;
  endfunction

endpackage

// File: hdl/ktc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ktc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/ktc_ctrl.sv
// Controller state machine: sequences lookup, insert and sweep over the entry RAM.
module ktc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  ktc_pkg::ktc_status_t  status,
  output ktc_pkg::ktc_cmd_t     cmd
);

  ktc_pkg::ktc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ktc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ktc_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = ktc_pkg::S_DISP;
      end
      ktc_pkg::S_DISP: begin
        unique case (status.op)
          ktc_pkg::OP_LOOKUP:
            state_nxt = status.count_zero ? ktc_pkg::S_LK_MISS : ktc_pkg::S_LK_CHK;
          ktc_pkg::OP_INSERT: state_nxt = ktc_pkg::S_INS;
          ktc_pkg::OP_SWEEP:
            state_nxt = status.count_zero ? ktc_pkg::S_SW_DONE : ktc_pkg::S_SW_CHK;
          default: state_nxt = ktc_pkg::S_IDLE;
        endcase
      end
      ktc_pkg::S_LK_CHK: begin
        if (status.hit) begin
          state_nxt = ktc_pkg::S_LK_HIT;
        end else if (status.idx_last) begin
          state_nxt = ktc_pkg::S_LK_MISS;
        end
      end
      ktc_pkg::S_LK_HIT, ktc_pkg::S_LK_MISS, ktc_pkg::S_INS, ktc_pkg::S_SW_DONE: begin
        if (status.slot_free) state_nxt = ktc_pkg::S_IDLE;
      end
      ktc_pkg::S_SW_CHK: begin
        if (status.expired) begin
          state_nxt = ktc_pkg::S_SW_REL;
        end else if (status.idx_last) begin
          state_nxt = ktc_pkg::S_SW_DONE;
        end
      end
      ktc_pkg::S_SW_REL: begin
        // released entry was the last one: the scan is over
        if (status.slot_free) begin
          state_nxt = status.idx_last ? ktc_pkg::S_SW_DONE : ktc_pkg::S_SW_MV;
        end
      end
      ktc_pkg::S_SW_MV: state_nxt = ktc_pkg::S_SW_CHK;
      default: state_nxt = ktc_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = (state_r == ktc_pkg::S_IDLE);
    unique case (state_r)
      ktc_pkg::S_IDLE: begin
        cmd.latch = in_tvalid;
      end
      ktc_pkg::S_DISP: begin
        if (((status.op == ktc_pkg::OP_LOOKUP) || (status.op == ktc_pkg::OP_SWEEP)) &&
            !status.count_zero) begin
          cmd.rd_en    = 1'b1;
          cmd.addr_sel = ktc_pkg::ADDR_IDX;
        end
      end
      ktc_pkg::S_LK_CHK, ktc_pkg::S_SW_CHK: begin
        // advance past a kept entry and prefetch the next one
        if ((state_r == ktc_pkg::S_LK_CHK) ? !status.hit : !status.expired) begin
          cmd.idx_inc = 1'b1;
          if (!status.idx_last) begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = ktc_pkg::ADDR_NEXT;
          end
        end
      end
      ktc_pkg::S_LK_HIT: begin
        if (status.slot_free) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = ktc_pkg::WR_TOUCH;
          cmd.emit    = 1'b1;
          cmd.kind    = ktc_pkg::KIND_LOOKUP;
          cmd.found   = 1'b1;
          cmd.tex_row = 1'b1;
          cmd.last    = 1'b1;
        end
      end
      ktc_pkg::S_LK_MISS: begin
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          cmd.kind = ktc_pkg::KIND_LOOKUP;
          cmd.last = 1'b1;
        end
      end
      ktc_pkg::S_INS: begin
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          cmd.kind = ktc_pkg::KIND_INSERT;
          cmd.full = status.full;
          cmd.last = 1'b1;
          if (!status.full) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = ktc_pkg::WR_INSERT;
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      ktc_pkg::S_SW_REL: begin
        if (status.slot_free) begin
          cmd.emit    = 1'b1;
          cmd.kind    = ktc_pkg::KIND_RELEASE;
          cmd.tex_row = 1'b1;
          cmd.cnt_dec = 1'b1;
          if (!status.idx_last) begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = ktc_pkg::ADDR_LAST;
          end
        end
      end
      ktc_pkg::S_SW_MV: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ktc_pkg::WR_MOVE;
      end
      ktc_pkg::S_SW_DONE: begin
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          cmd.kind = ktc_pkg::KIND_DONE;
          cmd.last = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: hdl/ktc_dp.sv
// Datapath: entry RAM, key compare, age check, counters and result register.
module ktc_dp #(
  parameter int CAPACITY = ktc_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ktc_pkg::ROW_W-1:0]      in_tdata,
  input  logic [1:0]                     in_tuser,
  input  logic                           cfg_wr_en,
  input  logic [ktc_pkg::IDLE_W-1:0]     cfg_wr_data,
  input  ktc_pkg::ktc_cmd_t              cmd,
  output ktc_pkg::ktc_status_t           status,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ktc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                     out_tuser,
  output logic                           out_tlast
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RW = ktc_pkg::ROW_W;
  localparam int FL = ktc_pkg::FRAME_LO;
  localparam int W32 = ktc_pkg::WORD32;

  logic [RW-1:0]             key_r;
  ktc_pkg::ktc_op_t          op_r;
  logic [CW-1:0]             count_r;
  logic [AW-1:0]             idx_r;
  logic [ktc_pkg::IDLE_W-1:0] max_idle_r;
  logic                      out_valid_r;
  logic [ktc_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [1:0]                out_kind_r;
  logic                      out_last_r;

  logic [RW-1:0] rd_row;
  logic [RW-1:0] wr_row;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] idx_next;
  logic [CW-1:0] count_m1;
  logic [W32:0]  age_limit;
  logic [W32-1:0] tex_val;

  assign idx_next = CW'(idx_r) + CW'(1);
  assign count_m1 = count_r - CW'(1);

  always_comb begin
    unique case (cmd.addr_sel)
      ktc_pkg::ADDR_IDX:  rd_addr = idx_r;
      ktc_pkg::ADDR_NEXT: rd_addr = idx_next[AW-1:0];
      ktc_pkg::ADDR_LAST: rd_addr = count_m1[AW-1:0];
      default:            rd_addr = idx_r;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      ktc_pkg::WR_INSERT: begin
        wr_addr = count_r[AW-1:0];
        wr_row  = key_r;
      end
      ktc_pkg::WR_TOUCH: begin
        wr_addr = idx_r;
        wr_row  = {key_r[FL +: W32], rd_row[FL-1:0]};
      end
      default: begin
        wr_addr = idx_r;
        wr_row  = rd_row;
      end
    endcase
  end

  ktc_ram #(
    .WIDTH  (RW),
    .DEPTH  (CAPACITY),
    .ADDR_W (AW)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_row)
  );

  // Released once last_used + max_idle falls strictly below the frame, no wrap
  assign age_limit = {1'b0, rd_row[FL +: W32]} + (W32 + 1)'(max_idle_r);

  always_comb begin
    status.op         = op_r;
    status.count_zero = (count_r == '0);
    status.full       = (count_r == CW'(CAPACITY));
    status.hit        = ktc_pkg::blur_equal(key_r[ktc_pkg::BLUR_LO +: W32],
                                            rd_row[ktc_pkg::BLUR_LO +: W32]) &&
                        (key_r[ktc_pkg::OUTLINE_W-1:0] == rd_row[ktc_pkg::OUTLINE_W-1:0]);
    status.expired    = age_limit < {1'b0, key_r[FL +: W32]};
    status.idx_last   = (idx_next == count_r);
    status.slot_free  = !out_valid_r || out_tready;
  end

  assign tex_val = cmd.tex_row ? rd_row[ktc_pkg::HANDLE_LO +: W32] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      op_r        <= ktc_pkg::OP_NONE;
      max_idle_r  <= ktc_pkg::IDLE_W'(ktc_pkg::IDLE_RESET);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_idle_r <= cfg_wr_data;
      end
      if (cmd.latch) begin
        op_r  <= ktc_pkg::ktc_op_t'(in_tuser);
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_next[AW-1:0];
      end
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_m1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      key_r <= in_tdata;
    end
    if (cmd.emit) begin
      out_data_r <= {(ktc_pkg::OUT_DATA_W - ktc_pkg::OUT_USED_W)'(0),
                     cmd.full, tex_val, cmd.found};
      out_kind_r <= cmd.kind;
      out_last_r <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// File: hdl/keyed_texture_cache_age_evict_core.sv
// Keyed texture cache with age eviction: top level joining controller and datapath.
//
// Input channel (in_*): one command per transaction, in_tuser selects lookup,
// insert or begin-frame sweep; in_tdata carries the 384-bit outline, blur bits,
// texture handle and frame number. Result channel (out_*): out_tuser kind,
// out_tlast marks the final result of a command.
// Configuration: cfg_wr_en writes max_idle_frames from cfg_wr_data; the user
// must write it only while idle, as the block itself does not enforce this.
// Throughput: one command at a time. A lookup compares the stored entries one
// per cycle through the entry RAM read port, up to the first hit. A sweep checks
// each entry in turn; per released entry it reads the last entry and writes it
// into the hole, and the scan ends there when the released entry is itself the
// last one.
// The input is ready again in the cycle after a command's final result is loaded,
// even while that result still waits in the output register.
// Reset empties the table and sets max_idle_frames to 80; the RAM contents are
// left as they are. A stalled receiver holds the output register, and any step
// that loads a result waits until the pending result is taken.
module keyed_texture_cache_age_evict_core #(
  parameter int CAPACITY = ktc_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // outline_word_0..5, blur_bits, texture_handle, frame_number
  input  logic [ktc_pkg::ROW_W-1:0]      in_tdata,
  // cmd
  input  logic [1:0]                     in_tuser,
  input  logic                           cfg_wr_en,
  input  logic [ktc_pkg::IDLE_W-1:0]     cfg_wr_data,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // found, texture_out, table_full, zero pad
  output logic [ktc_pkg::OUT_DATA_W-1:0] out_tdata,
  // result_kind
  output logic [1:0]                     out_tuser,
  output logic                           out_tlast
);

  ktc_pkg::ktc_cmd_t    cmd;
  ktc_pkg::ktc_status_t status;

  ktc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ktc_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

`ifndef SYNTHESIS
  a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == ktc_pkg::KIND_LOOKUP) || (out_tuser == ktc_pkg::KIND_INSERT))
    |-> out_tlast)
    else $error("lookup or insert result without tlast");

  a_release_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ktc_pkg::KIND_RELEASE) |-> !out_tlast && !out_tdata[0])
    else $error("release result with tlast or found set");

  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready while a sweep run is still in progress");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transaction");
`endif

endmodule
